>>> hw/rtl/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Holds register indexes, widths, the divider stage word type and shared helpers.
// No dependencies.
package bpc_pkg;

    localparam int DivBits = 32;

    typedef enum logic [2:0] {
        REG_P1    = 3'd0,
        REG_P2    = 3'd1,
        REG_P3    = 3'd2,
        REG_P4    = 3'd3,
        REG_P5    = 3'd4,
        REG_P6    = 3'd5,
        REG_P7    = 3'd6,
        REG_P8_P9 = 3'd7
    } reg_index_t;

    // One word travelling down the divider chain.
    typedef struct packed {
        logic                    valid;
        logic                    err;
        logic                    post_double;
        logic [DivBits-1:0]      rem;
        logic [DivBits-1:0]      dvd;
        logic [DivBits-1:0]      quo;
        logic [DivBits-1:0]      den;
    } div_word_t;

    // Signed divide by 2^k truncating toward zero.
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                     input int unsigned k);
        logic signed [31:0] bias;
        begin
            bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
            sdiv_pow2 = (a + bias) >>> k;
        end
    endfunction

endpackage

>>> hw/rtl/bpc_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit per cycle.
// Depends on bpc_pkg.
module bpc_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  bpc_pkg::div_word_t in_word,
    output bpc_pkg::div_word_t out_word
);
    import bpc_pkg::*;

    logic [DivBits:0]   trial;
    logic [DivBits-1:0] rem_shift;
    div_word_t          word_next;
    logic               valid_reg;
    div_word_t          data_reg;

    always_comb
    begin
        rem_shift = {in_word.rem[DivBits-2:0], in_word.dvd[DivBits-1]};
        trial     = {in_word.rem, in_word.dvd[DivBits-1]} - {1'b0, in_word.den};
        word_next = in_word;
        word_next.dvd = {in_word.dvd[DivBits-2:0], 1'b0};
        if (!trial[DivBits])
        begin
            word_next.rem = trial[DivBits-1:0];
            word_next.quo = {in_word.quo[DivBits-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = rem_shift;
            word_next.quo = {in_word.quo[DivBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_word.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= word_next;
    end

    always_comb
    begin
        out_word       = data_reg;
        out_word.valid = valid_reg;
    end
endmodule

>>> hw/rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
// Front-end arithmetic stages, a 32-cell divider chain and the final correction.
// Depends on bpc_pkg and bpc_div_cell.
//
// Usage: drive raw_pressure and fine_temperature with start high for one cycle;
// busy is always low, so a word is taken on every cycle that start is high. Each
// input word yields one result word: pressure_pa and status appear with done high
// for exactly one cycle, in input order. Throughput is one word per cycle; each
// word passes through the front end (four register stages), the 32-cell divider
// chain with one quotient bit per cell, and three correction stages.
// Coefficients are written through cfg_we, cfg_index and cfg_data while the
// block is idle; an index beyond the list is ignored. Reset clears every
// coefficient and all stage valid bits. The receiver cannot stall the block.
// A zero divisor gives pressure_pa 0 and status 1.
module barometric_pressure_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [19:0] raw_pressure,
    input  logic signed [31:0] fine_temperature,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] pressure_pa,
    output logic        status
);
    import bpc_pkg::*;

    localparam int Cells = DivBits;

    logic [15:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;
    logic [31:0] p89_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0; p2_reg <= '0; p3_reg <= '0; p4_reg <= '0;
            p5_reg <= '0; p6_reg <= '0; p7_reg <= '0; p89_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_P1:    p1_reg  <= cfg_data[15:0];
                REG_P2:    p2_reg  <= cfg_data[15:0];
                REG_P3:    p3_reg  <= cfg_data[15:0];
                REG_P4:    p4_reg  <= cfg_data[15:0];
                REG_P5:    p5_reg  <= cfg_data[15:0];
                REG_P6:    p6_reg  <= cfg_data[15:0];
                REG_P7:    p7_reg  <= cfg_data[15:0];
                REG_P8_P9: p89_reg <= cfg_data;
                default:   p1_reg  <= p1_reg;
            endcase
        end
    end

    logic signed [31:0] p1s, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
    assign p1s = {16'd0, p1_reg};
    assign p2s = {{16{p2_reg[15]}}, p2_reg};
    assign p3s = {{16{p3_reg[15]}}, p3_reg};
    assign p4s = {{16{p4_reg[15]}}, p4_reg};
    assign p5s = {{16{p5_reg[15]}}, p5_reg};
    assign p6s = {{16{p6_reg[15]}}, p6_reg};
    assign p7s = {{16{p7_reg[15]}}, p7_reg};
    assign p8s = {{16{p89_reg[15]}}, p89_reg[15:0]};
    assign p9s = {{16{p89_reg[31]}}, p89_reg[31:16]};

    assign busy = 1'b0;

    // Front end, stage 1: a and q, sq product.
    logic               v1_reg;
    logic signed [31:0] a1_reg, sq1_reg;
    logic [19:0]        raw1_reg;
    logic signed [31:0] a_c, q_c;
    always_comb
    begin
        a_c = sdiv_pow2(fine_temperature, 1) - 32'sd64000;
        q_c = sdiv_pow2(a_c, 2);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        a1_reg   <= a_c;
        sq1_reg  <= q_c * q_c;
        raw1_reg <= raw_pressure;
    end

    // Stage 2: independent products.
    logic               v2_reg;
    logic signed [31:0] b6_2_reg, a5_2_reg, t3_2_reg, t2_2_reg;
    logic [19:0]        raw2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        b6_2_reg <= sdiv_pow2(sq1_reg, 11) * p6s;
        a5_2_reg <= a1_reg * p5s;
        t3_2_reg <= p3s * sdiv_pow2(sq1_reg, 13);
        t2_2_reg <= p2s * a1_reg;
        raw2_reg <= raw1_reg;
    end

    // Stage 3: b sum and divisor term times p1.
    logic               v3_reg;
    logic signed [31:0] b3_reg, den3_reg;
    logic [19:0]        raw3_reg;
    logic signed [31:0] bsum_c, asum_c;
    always_comb
    begin
        bsum_c = b6_2_reg + (a5_2_reg <<< 1);
        bsum_c = sdiv_pow2(bsum_c, 2) + (p4s <<< 16);
        asum_c = sdiv_pow2(t3_2_reg, 3) + sdiv_pow2(t2_2_reg, 1);
        asum_c = sdiv_pow2(asum_c, 18) + 32'sd32768;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        b3_reg   <= bsum_c;
        den3_reg <= asum_c * p1s;
        raw3_reg <= raw2_reg;
    end

    // Stage 4: pr times 3125, divisor finished.
    logic               v4_reg;
    logic [31:0]        pr4_reg, den4_reg;
    logic signed [31:0] pre_c;
    always_comb
    begin
        pre_c = (32'sd1048576 - {12'd0, raw3_reg}) - sdiv_pow2(b3_reg, 12);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        pr4_reg  <= pre_c * 32'sd3125;
        den4_reg <= sdiv_pow2(den3_reg, 15);
    end

    // Divider chain.
    div_word_t chain [0:Cells];
    always_comb
    begin
        chain[0].valid       = v4_reg;
        chain[0].err         = (den4_reg == 32'd0);
        chain[0].post_double = pr4_reg[31];
        chain[0].rem         = '0;
        chain[0].dvd         = pr4_reg[31] ? pr4_reg : {pr4_reg[30:0], 1'b0};
        chain[0].quo         = '0;
        chain[0].den         = den4_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < Cells; gi++)
        begin : g_cell
            bpc_div_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_word  (chain[gi]),
                .out_word (chain[gi+1])
            );
        end
    endgenerate

    div_word_t dq;
    assign dq = chain[Cells];

    // Correction stage 1: pr and h squared.
    logic        vc1_reg, ec1_reg;
    logic [31:0] prc1_reg, hh1_reg;
    logic [31:0] prq_c, h_c;
    always_comb
    begin
        prq_c = dq.post_double ? {dq.quo[30:0], 1'b0} : dq.quo;
        h_c   = prq_c >> 3;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vc1_reg <= 1'b0;
        else        vc1_reg <= dq.valid;
    end
    always_ff @(posedge clk)
    begin
        ec1_reg  <= dq.err;
        prc1_reg <= prq_c;
        hh1_reg  <= h_c * h_c;
    end

    // Correction stage 2: coefficient products.
    logic               vc2_reg, ec2_reg;
    logic [31:0]        prc2_reg;
    logic signed [31:0] m9_reg, m8_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vc2_reg <= 1'b0;
        else        vc2_reg <= vc1_reg;
    end
    always_ff @(posedge clk)
    begin
        ec2_reg  <= ec1_reg;
        prc2_reg <= prc1_reg;
        m9_reg   <= p9s * $signed({13'd0, hh1_reg[31:13]});
        m8_reg   <= $signed({2'd0, prc1_reg[31:2]}) * p8s;
    end

    // Correction stage 3: final sum and output register.
    logic               done_reg, status_reg;
    logic [31:0]        pres_reg;
    logic signed [31:0] corr_c;
    always_comb
    begin
        corr_c = sdiv_pow2(m9_reg, 12) + sdiv_pow2(m8_reg, 13) + p7s;
        corr_c = $signed(prc2_reg) + sdiv_pow2(corr_c, 4);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= vc2_reg;
    end
    always_ff @(posedge clk)
    begin
        status_reg <= ec2_reg;
        pres_reg   <= ec2_reg ? 32'd0 : corr_c;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign pressure_pa = pres_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg |-> pres_reg == 32'd0)
        else $error("error result carries nonzero pressure");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ##(Cells) dq.valid)
        else $error("divider chain lost a word");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule

>>> dv/tb_top.sv
// Testbench for barometric_pressure_compensation: random and directed pressure words,
// checked against an in-bench predictor of the 32-bit integer compensation.
// Depends on bpc_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpc_pkg::*;

    typedef struct {
        logic [19:0] raw;
        logic [31:0] tfine;
    } sample_t;

    typedef struct {
        logic [31:0] pa;
        logic        st;
    } pressure_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [19:0] raw_pressure;
    logic [31:0] fine_temperature;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [31:0] pressure_pa;
    logic        status;

    logic [31:0] coef [0:7];
    sample_t     pending_samples[$];
    pressure_t   expected_pressures[$];
    int          mismatch_count;
    int          idle_cycles;
    int          gap_left;
    bit          allow_gaps;
    bit          hold_driver;

    barometric_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_pressure(raw_pressure), .fine_temperature(fine_temperature),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .pressure_pa(pressure_pa), .status(status)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] div_trunc(input logic signed [31:0] a,
                                                     input int d);
        logic signed [63:0] wide;
        begin
            wide = a;
            div_trunc = 32'(wide / d);
        end
    endfunction

    function automatic logic signed [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    function automatic pressure_t compensate(input sample_t s);
        logic signed [31:0] a, b, q, sq, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] pr, h;
        pressure_t r;
        begin
            p1 = {16'd0, coef[REG_P1][15:0]};
            p2 = sext16(coef[REG_P2][15:0]);
            p3 = sext16(coef[REG_P3][15:0]);
            p4 = sext16(coef[REG_P4][15:0]);
            p5 = sext16(coef[REG_P5][15:0]);
            p6 = sext16(coef[REG_P6][15:0]);
            p7 = sext16(coef[REG_P7][15:0]);
            p8 = sext16(coef[REG_P8_P9][15:0]);
            p9 = sext16(coef[REG_P8_P9][31:16]);
            a = div_trunc(s.tfine, 2) - 32'sd64000;
            q = div_trunc(a, 4);
            sq = q * q;
            b = div_trunc(sq, 2048) * p6;
            b = b + a * p5 * 2;
            b = div_trunc(b, 4) + p4 * 32'sd65536;
            a = div_trunc(div_trunc(p3 * div_trunc(sq, 8192), 8) + div_trunc(p2 * a, 2),
                          262144);
            a = div_trunc((32'sd32768 + a) * p1, 32768);
            pr = ((32'sd1048576 - $signed({12'd0, s.raw})) - div_trunc(b, 4096)) * 32'sd3125;
            if (a == 0)
            begin
                r.pa = 0;
                r.st = 1;
            end
            else
            begin
                if (pr < 32'h80000000)
                    pr = (pr << 1) / $unsigned(a);
                else
                    pr = (pr / $unsigned(a)) * 2;
                h = pr / 8;
                h = (h * h) / 8192;
                a = div_trunc(p9 * $signed(h), 4096);
                b = div_trunc($signed(pr / 4) * p8, 8192);
                r.pa = $signed(pr) + div_trunc(a + b + p7, 16);
                r.st = 0;
            end
            compensate = r;
        end
    endfunction

    // Driver: one word per accepted start, with random gaps while allowed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            raw_pressure <= 0;
            fine_temperature <= 0;
            gap_left <= 0;
        end
        else
        begin
            sample_t s;
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 0;
            end
            else if (pending_samples.size() > 0 && !hold_driver
                     && !(start && busy))
            begin
                if (allow_gaps && $urandom_range(0, 5) == 0)
                begin
                    gap_left <= $urandom_range(0, 2);
                    start <= 0;
                end
                else
                begin
                    s = pending_samples.pop_front();
                    raw_pressure <= s.raw;
                    fine_temperature <= s.tfine;
                    start <= 1;
                    expected_pressures.push_back(compensate(s));
                end
            end
            else if (!(start && busy))
                start <= 0;
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_pressures.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: pa=%h status=%b", pressure_pa, status);
                end
                else
                begin
                    pressure_t e;
                    e = expected_pressures.pop_front();
                    if (e.pa !== pressure_pa || e.st !== status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected pa=%h status=%b, got pa=%h status=%b",
                                     e.pa, e.st, pressure_pa, status);
                    end
                end
            end
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000)
            begin
                $display("FAIL barometric_pressure_compensation");
                $finish;
            end
        end
    end

    task automatic write_coef(input reg_index_t idx, input logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        coef[idx] = (idx == REG_P8_P9) ? v : {16'd0, v[15:0]};
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_pressures.size() > 0 || start)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic load_coefs(input int mode);
        for (int i = 0; i < 8; i++)
        begin
            logic [31:0] v;
            case (mode)
                0: v = $urandom();
                1: v = (i == 0) ? 32'hFFFF : ((i == 7) ? 32'h7FFF7FFF : 32'h7FFF);
                2: v = (i == 0) ? 32'h0001 : ((i == 7) ? 32'h80008000 : 32'h8000);
                default:
                    // Typical sensor calibration with a small random spread.
                    case (i)
                        0: v = 36477 + $urandom_range(0, 400);
                        1: v = 32'(-10685 + int'($urandom_range(0, 200)));
                        2: v = 3024 + $urandom_range(0, 50);
                        3: v = 2855 + $urandom_range(0, 50);
                        4: v = 140 + $urandom_range(0, 20);
                        5: v = 32'(-7);
                        6: v = 15500;
                        default: v = {16'(6000), 16'(-14600)};
                    endcase
            endcase
            write_coef(reg_index_t'(i), v);
        end
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        s.raw = 20'($urandom());
        if ($urandom_range(0, 3) == 0)
            s.tfine = $urandom();
        else
            s.tfine = 32'(int'($urandom_range(0, 300000)) - 100000);
        return s;
    endfunction

    initial
    begin
        sample_t s;
        mismatch_count = 0;
        idle_cycles = 0;
        allow_gaps = 1;
        hold_driver = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        for (int i = 0; i < 8; i++)
            coef[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // All coefficients zero: every word takes the zero divisor path.
        s.raw = 20'hFFFFF; s.tfine = 32'h7FFFFFFF;
        pending_samples.push_back(s);
        drain();

        load_coefs(3);
        for (int i = 0; i < 20; i++)
        begin
            s.raw = 20'h1 << i;
            s.tfine = 32'h1 << (i + 12);
            pending_samples.push_back(s);
        end
        s.raw = 0; s.tfine = 32'h80000000;
        pending_samples.push_back(s);
        s.raw = 20'hFFFFF; s.tfine = 32'h7FFFFFFF;
        pending_samples.push_back(s);
        s.raw = 0; s.tfine = 0;
        pending_samples.push_back(s);
        drain();

        // Zero divisor with p1 forced to 0.
        write_coef(REG_P1, 0);
        s.raw = 20'h5A5A5; s.tfine = 128000;
        pending_samples.push_back(s);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            load_coefs(phase % 4);
            for (int n = 0; n < 200; n++)
                pending_samples.push_back(rand_sample());
            if (phase == 2)
            begin
                // Hold the sender off until all results are back.
                while (pending_samples.size() > 100)
                    @(posedge clk);
                hold_driver = 1;
                while (expected_pressures.size() > 0)
                    @(posedge clk);
                hold_driver = 0;
            end
            if (phase == 5)
                allow_gaps = 0;
            drain();
        end

        if (mismatch_count == 0)
            $display("PASS barometric_pressure_compensation");
        else
            $display("FAIL barometric_pressure_compensation");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_div_cell.sv
hw/rtl/barometric_pressure_compensation.sv
dv/tb_top.sv
